// File: rtl/lsp_pkg.sv
// lsp_pkg: shared constants, types and key decode for the limit-spec parser
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

   // width of the parsed value, 32 to 64; the result field stays 64 bits
   localparam int VALUE_WIDTH = 64;
   localparam int LIMIT_WIDTH = 64;
   localparam int ACC_X_WIDTH = VALUE_WIDTH + 4;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // characters
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SOFT  = 8'h53;
   localparam logic [7:0] CH_HARD  = 8'h48;
   localparam logic [7:0] CH_KILO  = 8'h4B;
   localparam logic [7:0] CH_MEGA  = 8'h4D;
   localparam logic [7:0] CH_GIGA  = 8'h47;
   localparam logic [7:0] CH_TERA  = 8'h54;

   localparam logic [5:0] SHIFT_KILO = 6'd10;
   localparam logic [5:0] SHIFT_MEGA = 6'd20;
   localparam logic [5:0] SHIFT_GIGA = 6'd30;
   localparam logic [5:0] SHIFT_TERA = 6'd40;

   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [3:0]             resource;
      logic                   set_soft;
      logic                   set_hard;
      logic [LIMIT_WIDTH-1:0] limit_value;
      logic                   success;
      logic                   last_of_run;
   } rsp_type;

   // up to two words handed together from the parser to the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] resource;
   } key_type;

   function automatic key_type key_decode(input logic [7:0] ch);
      key_type k;
      k.hit = 1'b1;
      unique case (ch)
         8'h74:   k.resource = 4'd0;   // t cpu
         8'h66:   k.resource = 4'd1;   // f fsize
         8'h64:   k.resource = 4'd2;   // d data
         8'h73:   k.resource = 4'd3;   // s stack
         8'h63:   k.resource = 4'd4;   // c core
         8'h6D:   k.resource = 4'd5;   // m rss
         8'h75:   k.resource = 4'd6;   // u nproc
         8'h6E:   k.resource = 4'd7;   // n nofile
         8'h6C:   k.resource = 4'd8;   // l memlock
         8'h76:   k.resource = 4'd9;   // v as
         8'h69:   k.resource = 4'd11;  // i sigpending
         8'h71:   k.resource = 4'd12;  // q msgqueue
         8'h65:   k.resource = 4'd13;  // e nice
         8'h72:   k.resource = 4'd14;  // r rtprio
         default: begin
            k.hit      = 1'b0;
            k.resource = 4'd0;
         end
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// File: rtl/lsp_if.sv
// lsp_if: valid/ready channel interfaces for input bytes and results
// depends on lsp_pkg for the result width
`timescale 1ns / 1ps
`default_nettype none

interface lsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, output char_byte, output end_of_text, input ready);
   modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface lsp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [3:0]                     resource;
   logic                           set_soft;
   logic                           set_hard;
   logic [lsp_pkg::LIMIT_WIDTH-1:0] limit_value;
   logic                           success;
   logic                           last_of_run;

   modport source (output valid, output kind, output resource, output set_soft,
                   output set_hard, output limit_value, output success,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input resource, input set_soft,
                 input set_hard, input limit_value, input success,
                 input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/lsp_parse.sv
// lsp_parse: parser state registers and the per-byte decision logic
// depends on lsp_pkg; produces up to two result words per accepted byte
`timescale 1ns / 1ps
`default_nettype none

module lsp_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        char_byte,
   input  wire logic              end_of_text,
   output lsp_pkg::push_type      push
);

   typedef enum logic [1:0] {
      PH_KEY    = 2'd0,
      PH_FIRST  = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      MODE_BOTH = 2'd0,
      MODE_SOFT = 2'd1,
      MODE_HARD = 2'd2
   } mode_type;

   localparam int VW = lsp_pkg::VALUE_WIDTH;
   localparam int XW = lsp_pkg::ACC_X_WIDTH;

   phase_type         phase_ff, phase_in;
   mode_type          mode_ff, mode_in;
   logic [3:0]        res_ff, res_in;
   logic [VW-1:0]     acc_ff, acc_in;
   logic              err_ff, err_in;

   logic              is_digit;
   logic [XW-1:0]     acc_x10;
   logic              acc_ovf;
   logic [5:0]        shift;
   lsp_pkg::key_type  key;
   logic              consumed;
   logic              do_assign;
   logic [VW-1:0]     assign_val;
   logic              ok;
   lsp_pkg::rsp_type  assign_word;
   lsp_pkg::rsp_type  status_word;

   assign is_digit = (char_byte >= lsp_pkg::CH_ZERO) && (char_byte <= lsp_pkg::CH_NINE);
   // acc * 10 + digit, overflow when anything lands above the value width
   assign acc_x10 = ({4'b0000, acc_ff} << 3) + ({4'b0000, acc_ff} << 1)
                  + XW'(char_byte[3:0]);
   assign acc_ovf = acc_x10[XW-1:VW] != 4'b0000;
   assign key = lsp_pkg::key_decode(char_byte);

   always_comb begin
      priority case (char_byte)
         lsp_pkg::CH_KILO: shift = lsp_pkg::SHIFT_KILO;
         lsp_pkg::CH_MEGA: shift = lsp_pkg::SHIFT_MEGA;
         lsp_pkg::CH_GIGA: shift = lsp_pkg::SHIFT_GIGA;
         lsp_pkg::CH_TERA: shift = lsp_pkg::SHIFT_TERA;
         default:          shift = 6'd0;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      mode_in    = mode_ff;
      res_in     = res_ff;
      acc_in     = acc_ff;
      err_in     = err_ff;
      consumed   = 1'b0;
      do_assign  = 1'b0;
      assign_val = acc_ff;
      ok         = 1'b0;

      if (!err_ff) begin
         unique case (phase_ff)
            PH_DIGITS: begin
               if (is_digit) begin
                  if (acc_ovf) begin
                     err_in = 1'b1;
                  end else begin
                     acc_in = acc_x10[VW-1:0];
                  end
                  consumed = 1'b1;
               end else begin
                  // a suffix is eaten, any other byte goes on as the next key
                  do_assign  = 1'b1;
                  assign_val = acc_ff << shift;
                  phase_in   = PH_KEY;
                  acc_in     = '0;
                  consumed   = shift != 6'd0;
               end
            end
            PH_FIRST: begin
               if (char_byte == lsp_pkg::CH_BANG) begin
                  do_assign  = 1'b1;
                  assign_val = '1;
                  phase_in   = PH_KEY;
                  acc_in     = '0;
               end else if (is_digit) begin
                  acc_in   = VW'(char_byte[3:0]);
                  phase_in = PH_DIGITS;
               end else begin
                  err_in = 1'b1;
               end
               consumed = 1'b1;
            end
            default: begin
            end
         endcase

         if (!consumed && !err_in) begin
            priority if (char_byte == lsp_pkg::CH_SOFT) begin
               mode_in = MODE_SOFT;
            end else if (char_byte == lsp_pkg::CH_HARD) begin
               mode_in = MODE_HARD;
            end else if (key.hit) begin
               res_in   = key.resource;
               acc_in   = '0;
               phase_in = PH_FIRST;
            end else if (char_byte > lsp_pkg::CH_SPACE) begin
               err_in = 1'b1;
            end else begin
               // whitespace is skipped
            end
         end
      end

      if (end_of_text) begin
         // digits running into the end still give their assignment
         if (!err_in && phase_in == PH_DIGITS) begin
            do_assign  = 1'b1;
            assign_val = acc_in;
         end
         ok       = !err_in && phase_in != PH_FIRST;
         phase_in = PH_KEY;
         mode_in  = MODE_BOTH;
         res_in   = 4'd0;
         acc_in   = '0;
         err_in   = 1'b0;
      end
   end

   always_comb begin
      assign_word.kind        = lsp_pkg::KIND_ASSIGN;
      assign_word.resource    = res_ff;
      assign_word.set_soft    = mode_ff != MODE_HARD;
      assign_word.set_hard    = mode_ff != MODE_SOFT;
      assign_word.limit_value = lsp_pkg::LIMIT_WIDTH'(assign_val);
      assign_word.success     = 1'b0;
      assign_word.last_of_run = !end_of_text;

      status_word.kind        = lsp_pkg::KIND_STATUS;
      status_word.resource    = 4'd0;
      status_word.set_soft    = 1'b0;
      status_word.set_hard    = 1'b0;
      status_word.limit_value = '0;
      status_word.success     = ok;
      status_word.last_of_run = 1'b1;

      push.count  = 2'd0;
      push.first  = assign_word;
      push.second = status_word;
      if (accept) begin
         push.count = {1'b0, do_assign} + {1'b0, end_of_text};
         if (!do_assign) begin
            push.first = status_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEY;
         mode_ff  <= MODE_BOTH;
         res_ff   <= 4'd0;
         acc_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         res_ff   <= res_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lsp_queue.sv
// lsp_queue: small result queue, takes up to two words per cycle, gives one
// while out_ready is high; depends on lsp_pkg for the word type and depth
`timescale 1ns / 1ps
`default_nettype none

module lsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lsp_pkg::push_type push,
   output logic                   room,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output lsp_pkg::rsp_type       out_word
);

   localparam int PW = lsp_pkg::QUEUE_PTR_WIDTH;
   localparam int CW = lsp_pkg::QUEUE_CNT_WIDTH;

   lsp_pkg::rsp_type  entry_ff [lsp_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     wr_next;
   logic              pop;

   // room for a worst-case byte (assignment plus status)
   assign room      = count_ff <= CW'(lsp_pkg::QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_word  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + PW'(1);

   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/resource_limit_spec_parser.sv
// resource_limit_spec_parser: top level of the limit-spec byte parser
// depends on lsp_pkg, lsp_if, lsp_parse and lsp_queue
//
//   channel   dir  handshake          words
//   req_bus   in   valid/ready        char_byte[7:0], end_of_text
//   rsp_bus   out  valid/ready        kind, resource, set_soft, set_hard,
//                                     limit_value[63:0], success, last_of_run
//
// one byte per cycle: the byte is decoded and the parser state updated in the
// cycle it is taken, its results land in a four-word queue and leave one a cycle.
// a byte gives zero, one or two words; bytes are taken while the queue has two free.
// reset is synchronous and returns the parser to the start of a string.
// a stalled result side holds the queue and then the input, nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module resource_limit_spec_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   lsp_req_if.sink    req_bus,
   lsp_rsp_if.source  rsp_bus
);

   lsp_pkg::push_type push;
   lsp_pkg::rsp_type  out_word;
   logic              room;
   logic              accept;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid && room;

   lsp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_bus.char_byte),
      .end_of_text (req_bus.end_of_text),
      .push        (push)
   );

   lsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_word  (out_word)
   );

   assign rsp_bus.kind        = out_word.kind;
   assign rsp_bus.resource    = out_word.resource;
   assign rsp_bus.set_soft    = out_word.set_soft;
   assign rsp_bus.set_hard    = out_word.set_hard;
   assign rsp_bus.limit_value = out_word.limit_value;
   assign rsp_bus.success     = out_word.success;
   assign rsp_bus.last_of_run = out_word.last_of_run;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for resource_limit_spec_parser, byte stream in, limit words out
// depends on lsp_pkg, lsp_if and the parser rtl; a scoreboard class predicts every result word
`timescale 1ns / 1ps

module tb_top;

   localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - lsp_pkg::VALUE_WIDTH);
   localparam int REPORT_CAP = 100;
   localparam int LIVE_TARGET = 1050;

   typedef logic [7:0] byte_q_type[$];
   typedef enum logic [1:0] {PH_KEY, PH_FIRST, PH_DIGITS} parse_phase_type;
   typedef enum logic [1:0] {MODE_BOTH, MODE_SOFT, MODE_HARD} target_type;

   class limit_scoreboard;
      parse_phase_type  phase;
      target_type       mode;
      logic [3:0]       pend_res;
      logic [63:0]      acc;
      bit               err;
      lsp_pkg::rsp_type expected_words[$];
      lsp_pkg::rsp_type new_words[$];
      int               live_bytes = 0;
      int               assign_words = 0;
      int               status_words = 0;
      int               rejected = 0;
      int               mismatches = 0;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         phase    = PH_KEY;
         mode     = MODE_BOTH;
         pend_res = '0;
         acc      = '0;
         err      = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function int key_resource(logic [7:0] ch);
         case (ch)
            "t": return 0;
            "f": return 1;
            "d": return 2;
            "s": return 3;
            "c": return 4;
            "m": return 5;
            "u": return 6;
            "n": return 7;
            "l": return 8;
            "v": return 9;
            "i": return 11;
            "q": return 12;
            "e": return 13;
            "r": return 14;
            default: return -1;
         endcase
      endfunction

      function void emit_limit(logic [63:0] val);
         lsp_pkg::rsp_type w;
         w             = '0;
         w.kind        = lsp_pkg::KIND_ASSIGN;
         w.resource    = pend_res;
         w.set_soft    = (mode != MODE_HARD);
         w.set_hard    = (mode != MODE_SOFT);
         w.limit_value = val & VALUE_MASK;
         new_words.push_back(w);
         assign_words++;
         phase = PH_KEY;
         acc   = '0;
      endfunction

      function void take_key(logic [7:0] ch);
         int r;
         r = key_resource(ch);
         if (ch == lsp_pkg::CH_SOFT) begin
            mode = MODE_SOFT;
         end else if (ch == lsp_pkg::CH_HARD) begin
            mode = MODE_HARD;
         end else if (r >= 0) begin
            pend_res = r[3:0];
            acc      = '0;
            phase    = PH_FIRST;
         end else if (ch > lsp_pkg::CH_SPACE) begin
            err = 1;
         end
      endfunction

      function void note_byte(logic [7:0] ch, logic last);
         logic [63:0]      d;
         logic [5:0]       sh;
         bit               digit;
         bit               taken;
         lsp_pkg::rsp_type w;
         new_words.delete();
         digit = (ch >= lsp_pkg::CH_ZERO) && (ch <= lsp_pkg::CH_NINE);
         d     = {56'd0, ch - lsp_pkg::CH_ZERO};
         taken = 0;
         if (!err) begin
            live_bytes++;
            if (phase == PH_DIGITS) begin
               if (digit) begin
                  if (acc > (VALUE_MASK - d) / 64'd10) err = 1;
                  else acc = acc * 64'd10 + d;
                  taken = 1;
               end else begin
                  case (ch)
                     lsp_pkg::CH_KILO: sh = lsp_pkg::SHIFT_KILO;
                     lsp_pkg::CH_MEGA: sh = lsp_pkg::SHIFT_MEGA;
                     lsp_pkg::CH_GIGA: sh = lsp_pkg::SHIFT_GIGA;
                     lsp_pkg::CH_TERA: sh = lsp_pkg::SHIFT_TERA;
                     default:          sh = '0;
                  endcase
                  // a non-suffix byte closes the number and is then read as a key
                  if (sh != 0) begin
                     emit_limit(acc << sh);
                     taken = 1;
                  end else begin
                     emit_limit(acc);
                  end
               end
            end else if (phase == PH_FIRST) begin
               if (ch == lsp_pkg::CH_BANG) begin
                  emit_limit(VALUE_MASK);
               end else if (digit) begin
                  acc   = d;
                  phase = PH_DIGITS;
               end else begin
                  err = 1;
               end
               taken = 1;
            end
            if (!taken && !err) take_key(ch);
         end
         if (last) begin
            if (!err && phase == PH_DIGITS) emit_limit(acc);
            w         = '0;
            w.kind    = lsp_pkg::KIND_STATUS;
            w.success = !err && (phase != PH_FIRST);
            if (!w.success) rejected++;
            new_words.push_back(w);
            status_words++;
            clear_state();
         end
         if (new_words.size() > 0) new_words[new_words.size() - 1].last_of_run = 1'b1;
         foreach (new_words[i]) expected_words.push_back(new_words[i]);
      endfunction

      function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
         if (want === got) return 0;
         if (mismatches < REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         return 1;
      endfunction

      function void check_word(lsp_pkg::rsp_type got);
         lsp_pkg::rsp_type want;
         bit               bad;
         if (expected_words.size() == 0) begin
            if (mismatches < REPORT_CAP)
               $display("%0t: unexpected word, expected none, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         bad  = 0;
         bad |= field_differs("kind", 64'(want.kind), 64'(got.kind));
         bad |= field_differs("resource", 64'(want.resource), 64'(got.resource));
         bad |= field_differs("set_soft", 64'(want.set_soft), 64'(got.set_soft));
         bad |= field_differs("set_hard", 64'(want.set_hard), 64'(got.set_hard));
         bad |= field_differs("limit_value", 64'(want.limit_value), 64'(got.limit_value));
         bad |= field_differs("success", 64'(want.success), 64'(got.success));
         bad |= field_differs("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
         if (bad) mismatches++;
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on = 1;

   lsp_req_if req_bus();
   lsp_rsp_if rsp_bus();

   limit_scoreboard sb = new();

   resource_limit_spec_parser uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("resource_limit_spec_parser test failed");
      $finish;
   end

   // both handshakes sampled on the same edge, input noted before the result is checked
   always @(posedge clock) begin
      lsp_pkg::rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_byte(req_bus.char_byte, req_bus.end_of_text);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind        = rsp_bus.kind;
            got.resource    = rsp_bus.resource;
            got.set_soft    = rsp_bus.set_soft;
            got.set_hard    = rsp_bus.set_hard;
            got.limit_value = rsp_bus.limit_value;
            got.success     = rsp_bus.success;
            got.last_of_run = rsp_bus.last_of_run;
            sb.check_word(got);
         end
      end
   end

   // result side: ready high in random windows, stalled in random bursts while idle_on is set
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] ch, input logic last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.char_byte   <= ch;
      req_bus.end_of_text <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_run(input byte_q_type q);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   // hold the input until every predicted word has come out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void push_text(ref byte_q_type q, input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic void add_number(ref byte_q_type q);
      int r;
      int len;
      r = $urandom_range(0, 19);
      if (r < 19) begin
         if (r < 14) len = $urandom_range(1, 5);
         else if (r < 17) len = $urandom_range(6, 12);
         else len = $urandom_range(19, 20);
         for (int i = 0; i < len; i++)
            q.push_back(8'(lsp_pkg::CH_ZERO + $urandom_range(0, 9)));
      end else if ($urandom_range(0, 1) == 0) begin
         push_text(q, "18446744073709551615");
      end else begin
         push_text(q, "18446744073709551616");
      end
   endfunction

   function automatic void build_run(ref byte_q_type q);
      string keys;
      string suffixes;
      int    shape;
      int    sel;
      keys     = "tfdscmunlviqer";
      suffixes = "KMGT";
      q.delete();
      shape = $urandom_range(0, 9);
      if (shape < 8) begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) q.push_back(8'($urandom_range(0, 32)));
            sel = $urandom_range(0, 5);
            if (sel == 0) q.push_back(lsp_pkg::CH_SOFT);
            else if (sel == 1) q.push_back(lsp_pkg::CH_HARD);
            q.push_back(keys[$urandom_range(0, 13)]);
            if ($urandom_range(0, 4) == 0) begin
               q.push_back(lsp_pkg::CH_BANG);
            end else begin
               add_number(q);
               if ($urandom_range(0, 3) == 0) q.push_back(suffixes[$urandom_range(0, 3)]);
            end
         end
         if ($urandom_range(0, 5) == 0) q.push_back(8'($urandom_range(0, 32)));
      end else if (shape == 8) begin
         // key with its value cut off or replaced by a random byte
         if ($urandom_range(0, 1) == 0) q.push_back(lsp_pkg::CH_HARD);
         q.push_back(keys[$urandom_range(0, 13)]);
         if ($urandom_range(0, 1) == 0) q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   initial begin
      byte_q_type run;
      bit         mid_drain;
      mid_drain           = 0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.char_byte   <= '0;
      req_bus.end_of_text <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // whitespace, soft mode, infinity on the last byte
      run = {8'h00};
      push_text(run, "St!");
      send_run(run);
      // hard mode, kilo suffix, number closed by mega on the last byte
      run.delete();
      push_text(run, "Hd7Ke0M");
      send_run(run);
      // giga suffix, then a key with a bad value byte
      run.delete();
      push_text(run, "l4Gcx");
      send_run(run);
      // key with no value at the end of the string
      run.delete();
      push_text(run, "q");
      send_run(run);
      // bad key, the rest ignored
      run = {8'hFF};
      push_text(run, "m1");
      send_run(run);
      // tera shift drops the top bits
      run.delete();
      push_text(run, "u99999999T");
      send_run(run);
      drain_results();

      while (sb.live_bytes < LIVE_TARGET) begin
         if (sb.live_bytes >= LIVE_TARGET - 150) idle_on = 0;
         if (!mid_drain && sb.live_bytes >= LIVE_TARGET / 2) begin
            drain_results();
            mid_drain = 1;
         end
         build_run(run);
         send_run(run);
      end
      drain_results();
      repeat (20) @(posedge clock);

      $display("ran %0d parsed bytes giving %0d limit words and %0d status words",
               sb.live_bytes, sb.assign_words, sb.status_words);
      $display("%0d strings were rejected, %0d words mismatched, %0d still waiting",
               sb.rejected, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("resource_limit_spec_parser test passed");
      end else begin
         $display("resource_limit_spec_parser test failed");
      end
      $finish;
   end

endmodule
